@@ rtl/fthb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fthb_pkg
// Shared types and constants of the five-tuple hash blocklist filter.
// ----------------------------------------------------------------------------
package fthb_pkg;

  localparam logic OP_FRAME_BYTE  = 1'b0;
  localparam logic OP_ENTRY_WRITE = 1'b1;

  localparam logic [2:0] RSN_NONE      = 3'd0;
  localparam logic [2:0] RSN_TRUNCATED = 3'd1;
  localparam logic [2:0] RSN_NOT_IPV4  = 3'd2;
  localparam logic [2:0] RSN_OTHER     = 3'd3;
  localparam logic [2:0] RSN_BLOCKED   = 3'd4;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
  localparam logic [15:0] IP_END         = 16'd34;

  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_C3 = 32'h85ebca6b;
  localparam logic [31:0] MM_C4 = 32'hc2b2ae35;
  localparam logic [31:0] MM_E  = 32'he6546b64;
  localparam logic [31:0] MM_LEN = 32'd13;
  localparam logic [3:0]  HASH_LAST = 4'd13;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_JUDGE = 6'b000100,
    ST_HASH  = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  function automatic logic [31:0] rotl15(input logic [31:0] x);
    rotl15 = {x[16:0], x[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] x);
    rotl13 = {x[18:0], x[31:19]};
  endfunction

  function automatic logic [31:0] bswap(input logic [31:0] x);
    bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage
`default_nettype wire

@@ rtl/five_tuple_hash_blocklist_filter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// five_tuple_hash_blocklist_filter
// Parses Ethernet/IPv4 frames byte by byte, hashes the five-tuple with
// MurmurHash3 and searches a blocklist memory for the hash.
// ----------------------------------------------------------------------------
// channel | signals                    | direction
// input   | in_valid / in_stall + item | word in
// output  | out_valid / out_stall      | verdict out
//
// Frame bytes and blocklist writes are accepted only in the idle state.
// After the last byte a verdict passes through a judge state, the hash steps,
// a scan of the table and a load into the output register.
// Early checks skip the hash and the scan; a blocklist hit ends the scan early.
// After reset a pass over the table clears the valid marks.
// The verdict waits in an output register; input stalls whenever not idle.
// ----------------------------------------------------------------------------
module five_tuple_hash_blocklist_filter #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        operation,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic [9:0]  entry_index,
  input  wire logic [31:0] entry_hash,
  input  wire logic        entry_enable,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             drop,
  output logic [2:0]       drop_reason,
  output logic [31:0]      session_hash
);
  import fthb_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IW = (AW > 10) ? AW : 10;
  localparam logic [AW:0] DEPTH = (AW + 1)'(TABLE_DEPTH);

  state_t state;
  logic [15:0] byte_count;
  logic [15:0] ether_type;
  logic [3:0]  header_words;
  logic [7:0]  ip_protocol;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;

  logic [32:0] mem [TABLE_DEPTH];
  logic [32:0] rdata;
  logic [AW:0] scan_cnt;
  logic        chk;
  logic [3:0]  step;
  logic [31:0] h, k, h_next, k_next;
  logic [2:0]  reason;

  logic accept, wr_item, byte_item, wr_en, idx_ok;
  logic [AW-1:0] wr_addr;
  logic [32:0]   wr_data;
  logic [IW-1:0] idx_w;
  logic [3:0]  hw_eff;
  logic [15:0] base;
  logic [15:0] need;
  logic [31:0] blk, t;
  logic out_free;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign wr_item   = accept && (operation == OP_ENTRY_WRITE);
  assign byte_item = accept && (operation == OP_FRAME_BYTE);
  assign out_free  = !out_valid || !out_stall;

  assign idx_w  = IW'(entry_index);
  assign idx_ok = ({{(32 - IW){1'b0}}, idx_w} < 32'(TABLE_DEPTH));

  always_comb begin
    if (state == ST_CLEAR) begin
      wr_en   = (scan_cnt < DEPTH);
      wr_addr = scan_cnt[AW-1:0];
      wr_data = '0;
    end else begin
      wr_en   = wr_item && idx_ok;
      wr_addr = idx_w[AW-1:0];
      wr_data = {entry_enable, entry_hash};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[scan_cnt[AW-1:0]];
  end

  assign hw_eff = (byte_count == ETH_HDR_LEN) ? data_byte[3:0] : header_words;
  assign base   = ETH_HDR_LEN + {10'd0, hw_eff, 2'b00};
  assign need   = ETH_HDR_LEN + {10'd0, header_words, 2'b00} +
                  ((ip_protocol == PROTO_TCP) ? 16'd20 : 16'd8);

  always_comb begin
    if (step < 4'd3) begin
      blk = bswap(source_address);
    end else if (step < 4'd6) begin
      blk = bswap(dest_address);
    end else begin
      blk = {dest_port[7:0], dest_port[15:8], source_port[7:0], source_port[15:8]};
    end
    h_next = h;
    k_next = k;
    t      = '0;
    unique case (step)
      4'd0, 4'd3, 4'd6: k_next = blk * MM_C1;
      4'd1, 4'd4, 4'd7, 4'd10: k_next = rotl15(k) * MM_C2;
      4'd2, 4'd5, 4'd8: begin
        t      = rotl13(h ^ k);
        h_next = (t << 2) + t + MM_E;
      end
      4'd9: k_next = {24'd0, ip_protocol} * MM_C1;
      4'd11: begin
        t      = h ^ k ^ MM_LEN;
        t      = t ^ (t >> 16);
        h_next = t * MM_C3;
      end
      4'd12: begin
        t      = h ^ (h >> 13);
        h_next = t * MM_C4;
      end
      4'd13: h_next = h ^ (h >> 16);
      default: h_next = h;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      scan_cnt       <= '0;
      chk            <= 1'b0;
      out_valid      <= 1'b0;
      byte_count     <= '0;
      ether_type     <= '0;
      header_words   <= '0;
      ip_protocol    <= '0;
      source_address <= '0;
      dest_address   <= '0;
      source_port    <= '0;
      dest_port      <= '0;
      step           <= '0;
    end else begin
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (scan_cnt < DEPTH) begin
            scan_cnt <= scan_cnt + 1'b1;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (byte_item) begin
            if (byte_count != 16'hFFFF) byte_count <= byte_count + 1'b1;
            if (byte_count == 16'd12) ether_type[15:8] <= data_byte;
            if (byte_count == 16'd13) ether_type[7:0] <= data_byte;
            if (byte_count == 16'd14) header_words <= data_byte[3:0];
            if (byte_count == 16'd23) ip_protocol <= data_byte;
            if (byte_count >= 16'd26 && byte_count <= 16'd29) begin
              source_address <= {source_address[23:0], data_byte};
            end
            if (byte_count >= 16'd30 && byte_count <= 16'd33) begin
              dest_address <= {dest_address[23:0], data_byte};
            end
            if (byte_count == base) source_port[15:8] <= data_byte;
            if (byte_count == base + 16'd1) source_port[7:0] <= data_byte;
            if (byte_count == base + 16'd2) dest_port[15:8] <= data_byte;
            if (byte_count == base + 16'd3) dest_port[7:0] <= data_byte;
            if (last_byte) state <= ST_JUDGE;
          end
        end
        ST_JUDGE: begin
          h    <= '0;
          step <= '0;
          priority if (byte_count < ETH_HDR_LEN) begin
            reason <= RSN_TRUNCATED;
            state  <= ST_FIN;
          end else if (ether_type != ETHERTYPE_IPV4) begin
            reason <= RSN_NOT_IPV4;
            state  <= ST_FIN;
          end else if (byte_count < IP_END) begin
            reason <= RSN_TRUNCATED;
            state  <= ST_FIN;
          end else if (ip_protocol != PROTO_TCP && ip_protocol != PROTO_UDP) begin
            reason <= RSN_OTHER;
            state  <= ST_FIN;
          end else if (need > byte_count) begin
            reason <= RSN_TRUNCATED;
            state  <= ST_FIN;
          end else begin
            reason <= RSN_NONE;
            state  <= ST_HASH;
          end
        end
        ST_HASH: begin
          h    <= h_next;
          k    <= k_next;
          step <= step + 1'b1;
          if (step == HASH_LAST) begin
            scan_cnt <= '0;
            chk      <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (chk && rdata[32] && (rdata[31:0] == h)) begin
            reason <= RSN_BLOCKED;
            state  <= ST_FIN;
          end else if (scan_cnt < DEPTH) begin
            scan_cnt <= scan_cnt + 1'b1;
            chk      <= 1'b1;
          end else if (chk) begin
            chk <= 1'b0;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            drop           <= (reason != RSN_NONE);
            drop_reason    <= reason;
            session_hash   <= (step == HASH_LAST + 4'd1) ? h : 32'd0;
            step           <= '0;
            byte_count     <= '0;
            ether_type     <= '0;
            header_words   <= '0;
            ip_protocol    <= '0;
            source_address <= '0;
            dest_address   <= '0;
            source_port    <= '0;
            dest_port      <= '0;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && !(out_valid && out_stall)) |=> (out_valid && state == ST_IDLE))
    else $error("verdict not loaded");

  a_pass_reason: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !drop) |-> (drop_reason == RSN_NONE))
    else $error("pass with a drop reason");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_cnt <= DEPTH))
    else $error("scan ran past the table");

  a_blocked_hash: assert property (@(posedge clk) disable iff (rst)
    (out_valid && drop_reason == RSN_BLOCKED) |-> drop)
    else $error("blocked verdict without drop");

endmodule
`default_nettype wire
